/* src/dlecs_pkg.sv */
// Shared types and constants for the DLE character stuffer.
// No dependencies; compiled first.
`default_nettype none

package dlecs_pkg;

    localparam logic [7:0] CH_D        = 8'h44;
    localparam logic [7:0] CH_L        = 8'h4C;
    localparam logic [7:0] CH_E        = 8'h45;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam int SEQ_LEN = 6;
    localparam logic [2:0] SEQ_LAST = 3'(SEQ_LEN - 1);

    localparam logic [7:0] HDR_SEQ [0:SEQ_LEN-1] = '{8'h44, 8'h4C, 8'h45, 8'h53, 8'h54, 8'h58};
    localparam logic [7:0] ESC_SEQ [0:SEQ_LEN-1] = '{8'h44, 8'h4C, 8'h45, 8'h44, 8'h4C, 8'h45};
    localparam logic [7:0] TRL_SEQ [0:SEQ_LEN-1] = '{8'h44, 8'h4C, 8'h45, 8'h45, 8'h54, 8'h58};
    localparam logic [7:0] HELD_SEQ [0:1]        = '{8'h44, 8'h4C};

    // Held prefix of "DLE"; the value doubles as the number of held bytes.
    localparam logic [1:0] MP_NONE = 2'd0;
    localparam logic [1:0] MP_D    = 2'd1;
    localparam logic [1:0] MP_DL   = 2'd2;

    // Output segments of one item, in emission order.
    localparam logic [2:0] SEG_HDR  = 3'd0;
    localparam logic [2:0] SEG_PRE  = 3'd1;
    localparam logic [2:0] SEG_BODY = 3'd2;
    localparam logic [2:0] SEG_POST = 3'd3;
    localparam logic [2:0] SEG_TRL  = 3'd4;
    localparam int NUM_SEG = 5;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        BODY_NONE = 2'd0,
        BODY_BYTE = 2'd1,
        BODY_ESC  = 2'd2
    } t_body;

    // One classified item: which bursts the back end has to send.
    typedef struct packed {
        logic       hdr;
        logic [1:0] pre;
        t_body      body;
        logic [7:0] data;
        logic [1:0] post;
        logic       trl;
    } t_cmd;

endpackage

`default_nettype wire

/* src/dlecs_in_if.sv */
// Input channel of the DLE character stuffer: one raw message byte per item.
// No dependencies.
`default_nettype none

interface dlecs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_message;

    modport source (output valid, output in_byte, output end_of_message, input ready);
    modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

`default_nettype wire

/* src/dlecs_out_if.sv */
// Output channel of the DLE character stuffer: one frame byte per item.
// No dependencies.
`default_nettype none

interface dlecs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;

    modport source (output valid, output out_byte, output run_last, output frame_done,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input frame_done,
                    output ready);
endinterface

`default_nettype wire

/* src/dle_character_stuffer.sv */
// DLE-STX/DLE-ETX character stuffer. Each input item is one message byte; the
// output sends the stuffed frame one byte per item, with run_last on the final
// byte caused by an input item and frame_done on the closing 'X' of the trailer.
// Lowercase letters are sent as uppercase and each "DLE" is sent twice. A byte
// that extends a partial "DLE" match produces no output until the match resolves.
// The front end takes one input item per cycle whenever the command queue
// (Q_DEPTH entries) has room; the back end sends one output byte per cycle while
// the output is ready, so an item produces 0 to 13 output bytes (typically 1),
// and the input stalls whenever the queue is full, as when header, escape and
// trailer bursts or output backpressure keep the back end behind.
// Accepted items pass through the queue and then the back end's output register.
`default_nettype none

module dle_character_stuffer #(
    parameter int Q_DEPTH = dlecs_pkg::QUEUE_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dlecs_in_if.sink    i_in,
    dlecs_out_if.source o_out
);
    import dlecs_pkg::*;

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_valid;

    dlecs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    dlecs_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    dlecs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_valid (q_valid),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

/* src/dlecs_front.sv */
// Front end: accepts input bytes, tracks header and DLE match state,
// and turns each byte into a command for the queue. Uses dlecs_pkg, dlecs_in_if.
`default_nettype none

module dlecs_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    dlecs_in_if.sink           i_in,
    input  wire logic          i_q_full,
    output logic               o_push,
    output dlecs_pkg::t_cmd    o_cmd
);
    import dlecs_pkg::*;

    logic [1:0] r_mp;
    logic       r_hdr_sent;
    logic [1:0] n_mp;
    logic       n_hdr_sent;
    logic [1:0] mp;
    logic [7:0] b_up;
    logic [1:0] mp_mid;
    logic       accept;
    t_cmd       cmd;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;

    always_comb begin
        mp   = (r_mp == MP_D || r_mp == MP_DL) ? r_mp : MP_NONE;
        b_up = (i_in.in_byte inside {[CH_LOWER_A:CH_LOWER_Z]}) ?
               i_in.in_byte - CASE_OFFSET : i_in.in_byte;

        cmd      = '0;
        cmd.hdr  = !r_hdr_sent;
        cmd.data = b_up;

        if (mp == MP_D && b_up == CH_L) begin
            cmd.body = BODY_NONE;
            mp_mid   = MP_DL;
        end else if (mp == MP_DL && b_up == CH_E) begin
            cmd.body = BODY_ESC;
            mp_mid   = MP_NONE;
        end else begin
            // broken match: held bytes go out plain, byte judged afresh
            cmd.pre = mp;
            if (b_up == CH_D) begin
                cmd.body = BODY_NONE;
                mp_mid   = MP_D;
            end else begin
                cmd.body = BODY_BYTE;
                mp_mid   = MP_NONE;
            end
        end

        if (i_in.end_of_message) begin
            cmd.post   = mp_mid;
            cmd.trl    = 1'b1;
            n_mp       = MP_NONE;
            n_hdr_sent = 1'b0;
        end else begin
            n_mp       = mp_mid;
            n_hdr_sent = 1'b1;
        end
    end

    // an item that only holds bytes yields nothing to send
    assign o_push = accept && (cmd.hdr || cmd.pre != 2'd0 || cmd.body != BODY_NONE ||
                               cmd.post != 2'd0 || cmd.trl);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mp       <= MP_NONE;
            r_hdr_sent <= 1'b0;
        end else if (accept) begin
            r_mp       <= n_mp;
            r_hdr_sent <= n_hdr_sent;
        end
    end

endmodule

`default_nettype wire

/* src/dlecs_queue.sv */
// Small command queue between front and back end.
// Uses dlecs_pkg for the command type.
`default_nettype none

module dlecs_queue #(
    parameter int DEPTH = dlecs_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire dlecs_pkg::t_cmd   i_cmd,
    input  wire logic              i_pop,
    output dlecs_pkg::t_cmd        o_cmd,
    output logic                   o_valid,
    output logic                   o_full
);
    import dlecs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_cmd          r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_FULL);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue pop while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + CW'(1))
        else $error("queue count did not advance");
`endif

endmodule

`default_nettype wire

/* src/dlecs_back.sv */
// Back end: walks the queued command's segments and, unless the output stalls,
// sends one frame byte per cycle via an output register. Uses dlecs_pkg, dlecs_out_if.
`default_nettype none

module dlecs_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dlecs_pkg::t_cmd   i_cmd,
    input  wire logic              i_cmd_valid,
    output logic                   o_pop,
    dlecs_out_if.source            o_out
);
    import dlecs_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_frame_done;
    logic       r_fresh;
    logic [2:0] r_seg;
    logic [2:0] r_idx;

    logic [2:0] cur_seg;
    logic [2:0] cur_idx;
    logic [3:0] first_find;
    logic [3:0] next_find;
    logic [2:0] cur_len;
    logic       more_in_seg;
    logic       cmd_done;
    logic       fire;
    logic [7:0] n_byte;
    logic       n_frame_done;

    function automatic logic [2:0] seg_len(t_cmd c, logic [2:0] seg);
        logic [2:0] len;
        len = 3'd0;
        case (seg)
            SEG_HDR:  len = c.hdr ? SEQ_LAST + 3'd1 : 3'd0;
            SEG_PRE:  len = {1'b0, c.pre};
            SEG_BODY: begin
                case (c.body)
                    BODY_BYTE: len = 3'd1;
                    BODY_ESC:  len = SEQ_LAST + 3'd1;
                    default:   len = 3'd0;
                endcase
            end
            SEG_POST: len = {1'b0, c.post};
            SEG_TRL:  len = c.trl ? SEQ_LAST + 3'd1 : 3'd0;
            default:  len = 3'd0;
        endcase
        return len;
    endfunction

    // lowest non-empty segment at or after 'from': {found, segment}
    function automatic logic [3:0] seg_find(t_cmd c, logic [3:0] from);
        logic [3:0] res;
        res = '0;
        for (int s = NUM_SEG - 1; s >= 0; s--) begin
            if (4'(s) >= from && seg_len(c, 3'(s)) != 3'd0) begin
                res = {1'b1, 3'(s)};
            end
        end
        return res;
    endfunction

    always_comb begin
        first_find  = seg_find(i_cmd, 4'd0);
        cur_seg     = r_fresh ? first_find[2:0] : r_seg;
        cur_idx     = r_fresh ? 3'd0 : r_idx;
        cur_len     = seg_len(i_cmd, cur_seg);
        next_find   = seg_find(i_cmd, {1'b0, cur_seg} + 4'd1);
        more_in_seg = (cur_idx + 3'd1) < cur_len;
        cmd_done    = !more_in_seg && !next_find[3];

        case (cur_seg)
            SEG_HDR:  n_byte = HDR_SEQ[cur_idx];
            SEG_PRE:  n_byte = HELD_SEQ[cur_idx[0]];
            SEG_BODY: n_byte = (i_cmd.body == BODY_ESC) ? ESC_SEQ[cur_idx] : i_cmd.data;
            SEG_POST: n_byte = HELD_SEQ[cur_idx[0]];
            SEG_TRL:  n_byte = TRL_SEQ[cur_idx];
            default:  n_byte = i_cmd.data;
        endcase
        n_frame_done = (cur_seg == SEG_TRL) && (cur_idx == SEQ_LAST);
    end

    assign fire  = i_cmd_valid && (!r_valid || o_out.ready);
    assign o_pop = fire && cmd_done;

    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_byte;
    assign o_out.run_last   = r_run_last;
    assign o_out.frame_done = r_frame_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_fresh <= 1'b1;
            r_seg   <= SEG_HDR;
            r_idx   <= 3'd0;
        end else begin
            if (fire) begin
                r_valid <= 1'b1;
                if (cmd_done) begin
                    r_fresh <= 1'b1;
                end else begin
                    r_fresh <= 1'b0;
                    if (more_in_seg) begin
                        r_seg <= cur_seg;
                        r_idx <= cur_idx + 3'd1;
                    end else begin
                        r_seg <= next_find[2:0];
                        r_idx <= 3'd0;
                    end
                end
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte       <= n_byte;
            r_run_last   <= cmd_done;
            r_frame_done <= n_frame_done;
        end
    end

`ifndef SYNTHESIS
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_frame_done |-> r_run_last)
        else $error("frame end not marked as last byte of its item");

    a_pop_on_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> fire) else $error("command retired without sending a byte");

    a_burst_starts_dle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && cur_idx == 3'd0 && (cur_seg == SEG_HDR || cur_seg == SEG_TRL)
        |=> r_byte == CH_D) else $error("header or trailer does not open with DLE");
`endif

endmodule

`default_nettype wire

/* tb/tb_dlecs_checker.sv */
// Frame checker for the DLE character stuffer: watches both channels, predicts
// the stuffed frame bytes for every accepted message byte and compares them.
// Depends on dlecs_pkg, dlecs_in_if and dlecs_out_if.
module dlecs_frame_checker
    import dlecs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    dlecs_in_if         i_in,
    dlecs_out_if        i_out,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] data;
        logic       run_last;
        logic       frame_done;
    } t_frame_byte;

    localparam logic [47:0] HEADER_SEQ  = "DLESTX";
    localparam logic [47:0] ESCAPE_SEQ  = "DLEDLE";
    localparam logic [47:0] TRAILER_SEQ = "DLEETX";

    t_frame_byte frame_q[$];
    logic [1:0]  held_prefix;
    logic        header_done;
    int          fail_count;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fail_count   = 0;
        held_prefix  = MP_NONE;
        header_done  = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic void push_byte(logic [7:0] b, logic done);
        t_frame_byte fb;
        fb.data       = b;
        fb.run_last   = 1'b0;
        fb.frame_done = done;
        frame_q.push_back(fb);
    endfunction

    function automatic void push_seq(logic [47:0] seq, logic is_trailer);
        for (int k = 0; k < SEQ_LEN; k++)
            push_byte(seq[47 - 8 * k -: 8], is_trailer && k == SEQ_LEN - 1);
    endfunction

    // A held "D" or "DL" goes out as plain data.
    function automatic void flush_prefix();
        if (held_prefix == MP_D) begin
            push_byte(CH_D, 1'b0);
        end else if (held_prefix == MP_DL) begin
            push_byte(CH_D, 1'b0);
            push_byte(CH_L, 1'b0);
        end
        held_prefix = MP_NONE;
    endfunction

    function automatic void stuff_byte(logic [7:0] raw, logic eom);
        logic [7:0]  b;
        int          first;
        t_frame_byte tail;
        first = frame_q.size();
        b = raw;
        if (b >= CH_LOWER_A && b <= CH_LOWER_Z)
            b = b - CASE_OFFSET;
        if (!header_done) begin
            push_seq(HEADER_SEQ, 1'b0);
            header_done = 1'b1;
        end
        if (held_prefix == MP_D && b == CH_L) begin
            held_prefix = MP_DL;
        end else if (held_prefix == MP_DL && b == CH_E) begin
            push_seq(ESCAPE_SEQ, 1'b0);
            held_prefix = MP_NONE;
        end else begin
            flush_prefix();
            if (b == CH_D)
                held_prefix = MP_D;
            else
                push_byte(b, 1'b0);
        end
        if (eom) begin
            flush_prefix();
            push_seq(TRAILER_SEQ, 1'b1);
            header_done = 1'b0;
        end
        if (frame_q.size() > first) begin
            tail = frame_q.pop_back();
            tail.run_last = 1'b1;
            frame_q.push_back(tail);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_frame_byte want;
        if (!i_rst_n) begin
            held_prefix = MP_NONE;
            header_done = 1'b0;
            frame_q.delete();
        end else begin
            if (i_in.valid && i_in.ready)
                stuff_byte(i_in.in_byte, i_in.end_of_message);
            if (i_out.valid && i_out.ready) begin
                if (frame_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", i_out.out_byte));
                end else begin
                    want = frame_q.pop_front();
                    if (i_out.out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                                                  i_out.out_byte, want.data));
                    if (i_out.run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %b, want %b on byte %02h",
                                                  i_out.run_last, want.run_last, want.data));
                    if (i_out.frame_done !== want.frame_done)
                        report_mismatch($sformatf("frame_done %b, want %b on byte %02h",
                                                  i_out.frame_done, want.frame_done,
                                                  want.data));
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= frame_q.size();
    end

endmodule

/* tb/tb_dle_character_stuffer.sv */
// Top of the DLE character stuffer testbench: clock, reset, message stimulus,
// output backpressure, watchdog and verdict. Depends on the RTL and dlecs_frame_checker.
module tb_dle_character_stuffer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 105;
    localparam int DRAIN_CYCLES   = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic calm;
    int   fail_count;
    int   pending;
    int   idle_cycles;

    dlecs_in_if  in_ch ();
    dlecs_out_if out_ch ();

    dle_character_stuffer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    dlecs_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Mostly back-to-back, some short gaps, a few long ones; none while calm.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Biased toward the letters of "DLE" in both cases so escapes and broken
    // partial matches are common.
    function automatic logic [7:0] pick_char();
        string dle_letters = "DLEdle";
        int    r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return dle_letters[$urandom_range(0, 5)];
        else if (r < 6)
            return 8'($urandom_range(8'h41, 8'h5A));
        else if (r < 7)
            return 8'($urandom_range(8'h61, 8'h7A));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eom);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.in_byte        <= b;
        in_ch.end_of_message <= eom;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_message(input string msg);
        for (int i = 0; i < msg.len(); i++)
            send_byte(msg[i], i == msg.len() - 1);
    endtask

    initial begin : stimulus
        int sent;
        int len;
        i_rst_n              <= 1'b0;
        calm                 <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.in_byte        <= 8'h00;
        in_ch.end_of_message <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-byte frame, escapes, broken and trailing partial matches
        send_message("a");
        send_message("DLE");
        send_message("dlE");
        send_message("DX");
        send_message("DLQ");
        send_message("DDLDLE");
        send_message("DL");
        send_message("D");
        // non-printable and case-boundary bytes pass through
        send_byte(8'h00, 1'b0);
        send_byte(8'h60, 1'b0);
        send_byte(8'h7B, 1'b0);
        send_byte(8'hFF, 1'b1);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            len = $urandom_range(1, 12);
            calm <= ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len; k++)
                send_byte(pick_char(), k == len - 1);
            sent += len;
        end
        in_ch.valid <= 1'b0;

        // let the checker's count take in the last accepted item
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : backpressure
        int run;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            out_ch.ready <= 1'b1;
            run = $urandom_range(1, 16);
            repeat (run) @(posedge i_clk);
            run = pick_gap();
            if (run > 0) begin
                out_ch.ready <= 1'b0;
                repeat (run) @(posedge i_clk);
            end
        end
    end

    initial idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
